FILE: hdl/tdpt_pkg.sv
package tdpt_pkg;

  // Width of the tested number (two's complement).
  localparam int DATA_WIDTH = 32;

  // A trial divisor never exceeds sqrt(2^(DATA_WIDTH-1)) + 1, so half the
  // data width is enough to hold it.
  localparam int DIV_W = DATA_WIDTH / 2;

  // Bit counter for the serial remainder, one data bit per cycle.
  localparam int CNT_W = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [DIV_W-1:0]      div_t;
  typedef logic [CNT_W-1:0]      cnt_t;

endpackage

FILE: hdl/tdpt_num_if.sv
interface tdpt_num_if import tdpt_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

FILE: hdl/tdpt_res_if.sv
interface tdpt_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

FILE: hdl/trial_division_prime_test.sv
// channel  dir  payload                   word
// req      in   number   (signed, 32 b)   one number to test
// rsp      out  is_prime (1 b)            one verdict per number
//
// Steps: accept the word, then per trial divisor a bound check and a
//   bit-serial remainder over DATA_WIDTH dividend bits, then load the verdict
//   register. Negatives, 0 and 1 go straight from accept to the verdict.
// Reset: rst is synchronous, active high; returns the sequencer to idle and
//   empties the verdict register.
// Stalls: a new word is taken while the previous verdict still waits on rsp;
//   the sequencer only holds in its finish step if that verdict is still there.
module trial_division_prime_test import tdpt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tdpt_num_if.sink    req,
  tdpt_res_if.source  rsp
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_DIVIDE = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;

  // Working registers.
  data_t held_number;   // number under test
  data_t shreg;         // dividend bits, fed MSB first into the remainder
  div_t  trial_divisor; // current divisor d
  data_t square;        // d*d, kept by adding 2d+1 per step
  div_t  rem;           // partial remainder, always below d
  cnt_t  bit_cnt;       // dividend bit position
  logic  verdict;       // answer waiting for the output register

  // Shared remainder step: shift in one dividend bit, subtract d if it fits.
  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           fits;
  div_t           rem_next;

  always_comb begin
    trial    = {rem, shreg[DATA_WIDTH-1]};
    diff     = trial - {1'b0, trial_divisor};
    fits     = (trial >= {1'b0, trial_divisor});
    rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  // Output register is free when empty or being drained this cycle.
  logic out_free;
  assign out_free = !rsp.valid || rsp.ready;

  assign req.ready = (state == ST_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            // Negative, zero and one are never prime.
            if (req.number[DATA_WIDTH-1] || (req.number[DATA_WIDTH-2:1] == '0)) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          state <= (square > held_number) ? ST_FINISH : ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (bit_cnt == CNT_W'(DATA_WIDTH - 1)) begin
            state <= (rem_next == '0) ? ST_FINISH : ST_CHECK;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          held_number   <= data_t'(req.number);
          trial_divisor <= DIV_W'(2);
          square        <= DATA_WIDTH'(4);
          verdict       <= 1'b0;
        end
      end
      ST_CHECK: begin
        // No divisor up to sqrt(n) found: prime.
        verdict <= (square > held_number);
        shreg   <= held_number;
        rem     <= '0;
        bit_cnt <= '0;
      end
      ST_DIVIDE: begin
        rem     <= rem_next;
        shreg   <= {shreg[DATA_WIDTH-2:0], 1'b0};
        bit_cnt <= bit_cnt + cnt_t'(1);
        if (bit_cnt == CNT_W'(DATA_WIDTH - 1)) begin
          verdict       <= 1'b0;
          // (d+1)^2 = d^2 + 2d + 1
          square        <= square + DATA_WIDTH'({trial_divisor, 1'b0}) + DATA_WIDTH'(1);
          trial_divisor <= trial_divisor + div_t'(1);
        end
      end
      default: ;
    endcase
  end

  // Verdict register on the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      rsp.is_prime <= verdict;
    end
  end

endmodule

FILE: tb/tb_trial_division_prime_test.sv
module tb_trial_division_prime_test;
  import tdpt_pkg::*;

  // Run shape. Numbers are kept small enough that trial division stays short:
  // the work for a prime n grows with sqrt(n), so only the directed part goes
  // up to ~1e6 and large random values always carry a small factor.
  localparam int NUM_RANDOM      = 76;
  localparam int NUM_DIRECTED    = 24;
  localparam int HOLD_OFF_AT     = 30;      // verdict index where the sink stalls
  // Long enough for the word in flight and the next one (random primes up to
  // 2^18) to finish, so the sequencer parks in its finish step.
  localparam int HOLD_OFF_CYCLES = 40000;
  localparam int DRAIN_CYCLES    = 64;
  // Slowest word here is 1000003; longest quiet stretch is the
  // sink stall. Several times that, plus the widest gaps.
  localparam int QUIET_LIMIT     = 200000;

  typedef struct {
    data_t number;
    bit    known;     // verdict typed in below, else taken from the predictor
    bit    verdict;
  } row_t;

  typedef struct {
    data_t number;
    bit    verdict;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tdpt_num_if req_if ();
  tdpt_res_if rsp_if ();

  trial_division_prime_test dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Directed words: field extremes, every sign case, the tiny values with
  // fixed answers, squares of primes (divisor hits the bound exactly) and a
  // few primes / near-primes of growing size.
  row_t directed_rows [NUM_DIRECTED] = '{
    '{32'h8000_0000, 1'b1, 1'b0},   // most negative
    '{32'hFFFF_FFFF, 1'b1, 1'b0},   // -1
    '{32'hFFFF_FFFE, 1'b1, 1'b0},   // -2
    '{32'hAAAA_AAAA, 1'b1, 1'b0},   // negative, alternating bits
    '{32'd0,         1'b1, 1'b0},
    '{32'd1,         1'b1, 1'b0},
    '{32'd2,         1'b1, 1'b1},   // no divisor passes the bound
    '{32'd3,         1'b1, 1'b1},
    '{32'd4,         1'b1, 1'b0},
    '{32'd5,         1'b0, 1'b0},
    '{32'd9,         1'b0, 1'b0},
    '{32'd25,        1'b0, 1'b0},
    '{32'd49,        1'b0, 1'b0},
    '{32'd97,        1'b0, 1'b0},
    '{32'd121,       1'b0, 1'b0},
    '{32'd961,       1'b0, 1'b0},
    '{32'd1009,      1'b0, 1'b0},
    '{32'd65537,     1'b0, 1'b0},
    '{32'd1000001,   1'b0, 1'b0},   // 101 * 9901
    '{32'd1000003,   1'b0, 1'b0},   // prime, longest word of the run
    '{32'h7FFF_FFFE, 1'b1, 1'b0},   // largest even positive
    '{32'h7FFF_FFFD, 1'b0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0},
    '{32'h2AAA_AAAA, 1'b1, 1'b0}    // even
  };

  pending_t pending_verdicts [$];
  int       mismatches     = 0;
  int       words_sent     = 0;
  int       verdicts_seen  = 0;
  int       negatives_sent = 0;
  int       primes_sent    = 0;
  int       quiet_cycles   = 0;

  // Trial division on the 32-bit word; the sign bit alone rules a word out.
  function automatic bit prime_verdict(data_t n);
    int unsigned v;
    int unsigned d;
    v = n;
    if (n[DATA_WIDTH-1]) return 1'b0;
    if (v < 2) return 1'b0;
    for (d = 2; d <= v / d; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Every third block of 16 words runs back to back with no idling.
  function automatic int draw_gap(int idx);
    if ((idx / 16) % 3 == 1) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Mix: negatives with random low bits, full-range positives that carry a
  // small factor (so they finish fast but toggle the upper bits), a few
  // medium values and mostly small ones where primes are common.
  function automatic data_t random_number();
    int unsigned small_factors [6] = '{2, 3, 5, 7, 11, 13};
    int unsigned sel;
    int unsigned p;
    sel = $urandom_range(0, 99);
    if (sel < 15) return {1'b1, 31'($urandom)};
    if (sel < 35) begin
      p = small_factors[$urandom_range(0, 5)];
      return data_t'(p * $urandom_range(1, 32'h7FFF_FFFF / p));
    end
    if (sel < 45) return data_t'($urandom_range(2, 1 << 18));
    return data_t'($urandom_range(0, 5000));
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Offer one word after an optional gap. With no gap valid simply stays
  // high and only the payload changes, once per accepted word.
  task automatic send_number(data_t n, bit known, bit verdict, int gap);
    pending_t entry;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.number <= n;
    do @(posedge clk); while (!req_if.ready);
    entry.number  = n;
    entry.verdict = known ? verdict : prime_verdict(n);
    pending_verdicts.push_back(entry);
    words_sent++;
    if (n[DATA_WIDTH-1]) negatives_sent++;
    if (entry.verdict) primes_sent++;
  endtask

  // Source side: reset, directed table, random words, then drain.
  initial begin
    int idx;
    req_if.valid  <= 1'b0;
    req_if.number <= '0;
    rsp_if.ready  <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_number(directed_rows[i].number, directed_rows[i].known,
                  directed_rows[i].verdict, draw_gap(i));
    end
    for (idx = 0; idx < NUM_RANDOM; idx++) begin
      send_number(random_number(), 1'b0, 1'b0, draw_gap(idx + NUM_DIRECTED));
    end
    req_if.valid <= 1'b0;

    // Wait out the last verdicts, then a margin to catch any stray word.
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d numbers (%0d directed, %0d random): %0d negative, %0d prime",
             words_sent, NUM_DIRECTED, NUM_RANDOM, negatives_sent, primes_sent);
    $display("checked %0d verdicts with random gaps on both sides and one %0d-cycle sink stall",
             verdicts_seen, HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Sink side: random gaps before each verdict, no-idle stretches, and one
  // long hold-off while the source keeps offering, so the verdict register
  // and the sequencer both fill and req.ready drops.
  initial begin
    int gap;
    int taken;
    taken = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
      else gap = draw_gap(taken + 8);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      taken++;
    end
  end

  // Verdict check against the oldest pending word.
  always @(posedge clk) begin
    pending_t head;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %0b with no word pending", rsp_if.is_prime));
      end else begin
        head = pending_verdicts.pop_front();
        verdicts_seen++;
        if (rsp_if.is_prime !== head.verdict) begin
          report_mismatch($sformatf("number %0d: is_prime %0b, expected %0b",
                                    $signed(head.number), rsp_if.is_prime, head.verdict));
        end
      end
    end
  end

  // Watchdog: counts edges where no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < QUIET_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

FILE: sim.f
hdl/tdpt_pkg.sv
hdl/tdpt_num_if.sv
hdl/tdpt_res_if.sv
hdl/trial_division_prime_test.sv
tb/tb_trial_division_prime_test.sv
